FILE: design/tile_texel_blend_compositor_unit_macros.svh
// Assertion macros for the tile texel blend compositor.
// Included by the top level; no other dependencies.
`ifndef TILE_TEXEL_BLEND_COMPOSITOR_UNIT_MACROS_SVH
`define TILE_TEXEL_BLEND_COMPOSITOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TTBC_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ttbc: same-cycle check failed");

`define TTBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ttbc: next-cycle check failed");

`else

`define TTBC_ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`define TTBC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: design/ttbc_pkg.sv
// Shared types and constants of the tile texel blend compositor.
// No dependencies; used by every module of the block but ttbc_ram.
package ttbc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 512;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    localparam int COORD_W    = 11;
    localparam int SIZE_W     = 6;
    localparam int COLOR_W    = 32;
    localparam int INDEX_W    = 19;
    localparam int ROW_W      = 21;
    localparam int OFFS_W     = 12;
    localparam int PROD_W     = 24;
    localparam int SUM_W      = 23;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_X     = 2'd0,
        CFG_AREA_Y     = 2'd1,
        CFG_AREA_WIDTH = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_AVERAGE     = 2'd0,
        MODE_ADD         = 2'd1,
        MODE_SUB         = 2'd2,
        MODE_ADD_QUARTER = 2'd3
    } blend_mode_t;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BLEND = 2'd2
    } op_t;

    // One command for the frame store side.
    typedef struct packed {
        op_t                op;
        logic               oob;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        blend_mode_t        mode;
    } cmd_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } fifo_status_t;

endpackage

FILE: design/tile_texel_blend_compositor_unit.sv
// Top level of the tile texel blend compositor: front, command queue and back.
// Depends on ttbc_pkg, ttbc_front, ttbc_fifo, ttbc_back and the macros header.
//
// Draw and read beats are taken at one per cycle, sustained while the queue
// is not full. A beat is held in the intake register, where its row product
// is already formed and the tile column counter and row base give its frame
// store address, then passes a four-entry queue to the store side. There the
// frame store read is issued as the command leaves the queue and the write or
// blend happens in the cycle after; the write of the previous command is
// forwarded, so neighbouring texels on the same pixel need no wait. With the
// queue empty, a read passes the intake register, the queue and the store
// stage before its pixel reaches the result register on m_axis. A stall on
// the result side stops the store side only while it holds a read, and the
// intake keeps taking beats until the queue fills. The frame store is not
// cleared after reset: a pixel must be written before it is read or blended
// against.
module tile_texel_blend_compositor_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ttbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttbc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // dst_x[10:0], dst_y[21:11], tile_size[27:22], texel_color[59:28],
    // visible[60], blend_enable[61], blend_mode[63:62], read_index[82:64], zero fill
    input  logic [ttbc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[0], first_of_tile[1]
    input  logic [ttbc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel[31:0]
    output logic [ttbc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

`include "tile_texel_blend_compositor_unit_macros.svh"

    logic                   fifo_push;
    logic                   fifo_pop;
    ttbc_pkg::cmd_t         push_cmd;
    ttbc_pkg::cmd_t         head_cmd;
    ttbc_pkg::fifo_status_t fifo_status;
    logic                   push_only;
    logic [ttbc_pkg::FIFO_CW-1:0] q_count;

    ttbc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (fifo_push),
        .push_cmd      (push_cmd),
        .queue_full    (fifo_status.full)
    );

    ttbc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head_cmd (head_cmd),
        .status   (fifo_status)
    );

    ttbc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .queue_empty   (fifo_status.empty),
        .pop           (fifo_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign push_only = fifo_push && !fifo_pop;
    assign q_count   = fifo_status.count;

    `TTBC_ASSERT_IMPLIES(a_queue_no_overflow, aclk, aresetn, fifo_push, !fifo_status.full)
    `TTBC_ASSERT_IMPLIES(a_queue_no_underflow, aclk, aresetn, fifo_pop, !fifo_status.empty)
    `TTBC_ASSERT_NEXT(a_count_up, aclk, aresetn, push_only, q_count == $past(q_count) + 1'b1)

endmodule

FILE: design/ttbc_ram.sv
// Generic simple dual-port RAM with a registered, read-first read port.
// No dependencies.
module ttbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/ttbc_front.sv
// Front part: configuration registers, item intake, tile counters and address forming.
// Depends on ttbc_pkg; feeds the command queue.
module ttbc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ttbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ttbc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [ttbc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             push,
    output ttbc_pkg::cmd_t                   push_cmd,
    input  logic                             queue_full
);

    logic signed [ttbc_pkg::COORD_W-1:0]  area_x_reg;
    logic signed [ttbc_pkg::COORD_W-1:0]  area_y_reg;
    logic        [ttbc_pkg::COORD_W-1:0]  area_width_reg;

    // Intake stage.
    logic                                 s1_valid_reg;
    logic                                 s1_kind_reg;
    logic                                 s1_first_reg;
    logic [ttbc_pkg::SIZE_W-1:0]          s1_size_reg;
    logic [ttbc_pkg::COLOR_W-1:0]         s1_color_reg;
    logic                                 s1_visible_reg;
    logic                                 s1_blend_reg;
    ttbc_pkg::blend_mode_t                s1_mode_reg;
    logic [ttbc_pkg::INDEX_W-1:0]         s1_index_reg;
    logic signed [ttbc_pkg::OFFS_W-1:0]   s1_xoff_reg;
    logic signed [ttbc_pkg::PROD_W-1:0]   s1_prod_reg;

    // Tile walking state.
    logic [ttbc_pkg::SIZE_W-1:0]          col_reg;
    logic [ttbc_pkg::SIZE_W-1:0]          col_next;
    logic signed [ttbc_pkg::ROW_W-1:0]    row_reg;
    logic signed [ttbc_pkg::ROW_W-1:0]    row_next;

    logic                                 accept;
    logic                                 s1_fire;
    logic signed [ttbc_pkg::COORD_W-1:0]  in_dst_x;
    logic signed [ttbc_pkg::COORD_W-1:0]  in_dst_y;
    logic signed [ttbc_pkg::OFFS_W-1:0]   row_sum;
    logic signed [ttbc_pkg::PROD_W-1:0]   prod;
    logic signed [ttbc_pkg::ROW_W-1:0]    base_sel;
    logic [ttbc_pkg::SIZE_W-1:0]          col_sel;
    logic [ttbc_pkg::SIZE_W-1:0]          col_inc;
    logic signed [ttbc_pkg::PROD_W-1:0]   step_sum;
    logic signed [ttbc_pkg::SUM_W-1:0]    addr_sum;
    logic [31:0]                          addr_wide;
    logic [31:0]                          index_wide;
    logic                                 in_range;

    function automatic logic signed [ttbc_pkg::ROW_W-1:0] sat_row(
        input logic signed [ttbc_pkg::PROD_W-1:0] v
    );
        logic signed [ttbc_pkg::PROD_W-1:0] lo;
        logic signed [ttbc_pkg::PROD_W-1:0] hi;
        lo = -(ttbc_pkg::PROD_W'(1) <<< (ttbc_pkg::ROW_W - 1));
        hi = (ttbc_pkg::PROD_W'(1) <<< (ttbc_pkg::ROW_W - 1)) - ttbc_pkg::PROD_W'(1);
        if (v < lo) begin
            return lo[ttbc_pkg::ROW_W-1:0];
        end else if (v > hi) begin
            return hi[ttbc_pkg::ROW_W-1:0];
        end
        return v[ttbc_pkg::ROW_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_x_reg     <= '0;
            area_y_reg     <= '0;
            area_width_reg <= 11'd1024;
        end else if (cfg_wr_en) begin
            unique case (ttbc_pkg::cfg_index_t'(cfg_index))
                ttbc_pkg::CFG_AREA_X:     area_x_reg     <= cfg_wdata;
                ttbc_pkg::CFG_AREA_Y:     area_y_reg     <= cfg_wdata;
                ttbc_pkg::CFG_AREA_WIDTH: area_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The row product only depends on the item and the registers, so it is
    // formed in the intake stage, ahead of the tile state.
    assign in_dst_x = s_axis_tdata[10:0];
    assign in_dst_y = s_axis_tdata[21:11];
    assign row_sum  = ttbc_pkg::OFFS_W'(area_y_reg) + ttbc_pkg::OFFS_W'(in_dst_y);
    assign prod     = ttbc_pkg::PROD_W'(row_sum)
                    * ttbc_pkg::PROD_W'(signed'({1'b0, area_width_reg}));

    assign s1_fire       = s1_valid_reg && !queue_full;
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg    <= s_axis_tuser[0];
            s1_first_reg   <= s_axis_tuser[1];
            s1_size_reg    <= s_axis_tdata[27:22];
            s1_color_reg   <= s_axis_tdata[59:28];
            s1_visible_reg <= s_axis_tdata[60];
            s1_blend_reg   <= s_axis_tdata[61];
            s1_mode_reg    <= ttbc_pkg::blend_mode_t'(s_axis_tdata[63:62]);
            s1_index_reg   <= s_axis_tdata[82:64];
            s1_xoff_reg    <= ttbc_pkg::OFFS_W'(area_x_reg) + ttbc_pkg::OFFS_W'(in_dst_x);
            s1_prod_reg    <= prod;
        end
    end

    assign base_sel = s1_first_reg ? sat_row(s1_prod_reg) : row_reg;
    assign col_sel  = s1_first_reg ? '0 : col_reg;
    assign col_inc  = col_sel + ttbc_pkg::SIZE_W'(1);
    assign step_sum = ttbc_pkg::PROD_W'(base_sel)
                    + ttbc_pkg::PROD_W'(signed'({1'b0, area_width_reg}));
    assign addr_sum = ttbc_pkg::SUM_W'(base_sel) + ttbc_pkg::SUM_W'(s1_xoff_reg)
                    + ttbc_pkg::SUM_W'(signed'({1'b0, col_sel}));
    assign addr_wide  = 32'(addr_sum);
    assign index_wide = 32'(s1_index_reg);
    assign in_range   = !addr_sum[ttbc_pkg::SUM_W-1]
                      && (addr_wide < 32'(ttbc_pkg::STORE_SIZE));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s1_fire && !s1_kind_reg) begin
            if (col_inc == s1_size_reg) begin
                col_next = '0;
                row_next = sat_row(step_sum);
            end else begin
                col_next = col_inc;
                row_next = base_sel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Invisible texels and texels outside the store only move the counters.
    always_comb begin
        push_cmd.color = s1_color_reg;
        push_cmd.mode  = s1_mode_reg;
        if (s1_kind_reg) begin
            push_cmd.op   = ttbc_pkg::OP_READ;
            push_cmd.oob  = index_wide >= 32'(ttbc_pkg::STORE_SIZE);
            push_cmd.addr = index_wide[ttbc_pkg::ADDR_W-1:0];
            push          = s1_fire;
        end else begin
            push_cmd.op   = s1_blend_reg ? ttbc_pkg::OP_BLEND : ttbc_pkg::OP_WRITE;
            push_cmd.oob  = 1'b0;
            push_cmd.addr = addr_wide[ttbc_pkg::ADDR_W-1:0];
            push          = s1_fire && s1_visible_reg && in_range;
        end
    end

endmodule

FILE: design/ttbc_fifo.sv
// Short command queue between the front and back parts.
// Depends on ttbc_pkg.
module ttbc_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ttbc_pkg::cmd_t         push_cmd,
    input  logic                   pop,
    output ttbc_pkg::cmd_t         head_cmd,
    output ttbc_pkg::fifo_status_t status
);

    ttbc_pkg::cmd_t                   mem_reg [ttbc_pkg::FIFO_DEPTH];
    logic [ttbc_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [ttbc_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [ttbc_pkg::FIFO_CW-1:0]     count_reg;
    logic [ttbc_pkg::FIFO_CW-1:0]     count_next;

    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == ttbc_pkg::FIFO_CW'(ttbc_pkg::FIFO_DEPTH);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ttbc_pkg::FIFO_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ttbc_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + ttbc_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + ttbc_pkg::FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/ttbc_back.sv
// Back part: frame store access, blending with write forwarding, result register.
// Depends on ttbc_pkg and ttbc_ram.
module ttbc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ttbc_pkg::cmd_t                    head_cmd,
    input  logic                              queue_empty,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ttbc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic                             b2_valid_reg;
    ttbc_pkg::cmd_t                   b2_cmd_reg;
    logic                             fwd_valid_reg;
    logic [ttbc_pkg::ADDR_W-1:0]      fwd_addr_reg;
    logic [ttbc_pkg::COLOR_W-1:0]     fwd_data_reg;
    logic                             out_valid_reg;
    logic [ttbc_pkg::OUT_DATA_W-1:0]  out_data_reg;

    logic                             advance;
    logic                             b2_is_read;
    logic                             we;
    logic [ttbc_pkg::COLOR_W-1:0]     rdata;
    logic [ttbc_pkg::COLOR_W-1:0]     stored;
    logic [ttbc_pkg::COLOR_W-1:0]     wdata;

    function automatic logic [7:0] mix_channel(
        input ttbc_pkg::blend_mode_t mode,
        input logic [7:0]            s,
        input logic [7:0]            t
    );
        logic [8:0] sum;
        logic [8:0] qsum;
        sum  = {1'b0, s} + {1'b0, t};
        qsum = {1'b0, s} + {3'b000, t[7:2]};
        unique case (mode)
            ttbc_pkg::MODE_AVERAGE:     return sum[8:1];
            ttbc_pkg::MODE_ADD:         return sum[8] ? 8'hFF : sum[7:0];
            ttbc_pkg::MODE_SUB:         return (s > t) ? s - t : 8'h00;
            ttbc_pkg::MODE_ADD_QUARTER: return qsum[8] ? 8'hFF : qsum[7:0];
        endcase
    endfunction

    // Blended pixels always come out opaque.
    function automatic logic [ttbc_pkg::COLOR_W-1:0] blend_pixel(
        input ttbc_pkg::blend_mode_t         mode,
        input logic [ttbc_pkg::COLOR_W-1:0]  dst,
        input logic [ttbc_pkg::COLOR_W-1:0]  src
    );
        logic [ttbc_pkg::COLOR_W-1:0] res;
        res = 32'hFF00_0000;
        for (int ch = 0; ch < 3; ch++) begin
            res[8*ch +: 8] = mix_channel(mode, dst[8*ch +: 8], src[8*ch +: 8]);
        end
        return res;
    endfunction

    // The stage only stops while it holds a read beat the result register cannot take.
    assign b2_is_read = b2_cmd_reg.op == ttbc_pkg::OP_READ;
    assign advance    = !b2_valid_reg || !b2_is_read || !out_valid_reg || m_axis_tready;
    assign pop        = advance && !queue_empty;

    ttbc_ram #(
        .WIDTH (ttbc_pkg::COLOR_W),
        .DEPTH (ttbc_pkg::STORE_SIZE)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (b2_cmd_reg.addr),
        .wdata (wdata),
        .re    (pop),
        .raddr (head_cmd.addr),
        .rdata (rdata)
    );

    // The read was issued as the command left the queue, while the previous
    // command wrote, so that write may not be in the read data yet; the last
    // write always matches the store, so taking it on an address match is safe.
    assign stored = (fwd_valid_reg && fwd_addr_reg == b2_cmd_reg.addr) ? fwd_data_reg : rdata;

    always_comb begin
        we    = 1'b0;
        wdata = b2_cmd_reg.color;
        unique case (b2_cmd_reg.op)
            ttbc_pkg::OP_WRITE: we = b2_valid_reg;
            ttbc_pkg::OP_BLEND: begin
                we    = b2_valid_reg;
                wdata = blend_pixel(b2_cmd_reg.mode, stored, b2_cmd_reg.color);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                b2_valid_reg <= pop;
            end
            if (we) begin
                fwd_valid_reg <= 1'b1;
            end
            if (b2_valid_reg && b2_is_read && advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b2_cmd_reg <= head_cmd;
        end
        if (we) begin
            fwd_addr_reg <= b2_cmd_reg.addr;
            fwd_data_reg <= wdata;
        end
        if (b2_valid_reg && b2_is_read && advance) begin
            out_data_reg <= b2_cmd_reg.oob ? '0 : stored;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
